// ===== sv/packet_loss_delay_monitor_macros.svh =====
// Assertion macros for the packet loss and delay monitor.
`ifndef PACKET_LOSS_DELAY_MONITOR_MACROS_SVH
`define PACKET_LOSS_DELAY_MONITOR_MACROS_SVH
// Checks that a condition implies a consequence in the same cycle.
`define PLDM_ASSERT_IMP(label, clk, rst_n, cond, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
		else $error(msg);
// Checks that a condition implies a consequence in the next cycle.
`define PLDM_ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
		else $error(msg);
`endif

// ===== sv/pldm_pkg.sv =====
// Package with types and constants for the packet loss and delay monitor.
package pldm_pkg;
	localparam int NUM_BINS_DEF = 256;
	localparam logic [1:0] CMD_PACKET = 2'd0;
	localparam logic [1:0] CMD_CLEAR  = 2'd1;
	localparam logic [1:0] CMD_READ   = 2'd2;
	localparam logic [1:0] REG_FLOW   = 2'd0;
	localparam logic [1:0] REG_HEN    = 2'd1;
	localparam logic [1:0] REG_DBW    = 2'd2;
	localparam logic [1:0] REG_VBW    = 2'd3;

	typedef struct packed {
		logic [1:0]  command;
		logic [31:0] seq_number;
		logic [15:0] packet_bytes;
		logic [31:0] flow_id;
		logic [31:0] arrival_time;
		logic [31:0] send_time;
		logic [7:0]  bin_index;
	} req_t;

	typedef struct packed {
		logic [31:0] packets_total;
		logic [63:0] bytes_total;
		logic [31:0] lost_total;
		logic        loss_event;
		logic [31:0] flow_packets;
		logic [31:0] current_delay;
		logic [31:0] current_variation;
		logic [31:0] min_delay;
		logic [63:0] delay_sum;
		logic [63:0] variation_sum;
		logic [31:0] delay_bin_count;
		logic [31:0] variation_bin_count;
	} rsp_t;
endpackage

// ===== sv/pldm_req_if.sv =====
// Valid/ready channel interface carrying monitor requests.
interface pldm_req_if import pldm_pkg::*; ();
	logic valid;
	logic ready;
	req_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== sv/pldm_rsp_if.sv =====
// Valid/ready channel interface carrying monitor results.
interface pldm_rsp_if import pldm_pkg::*; ();
	logic valid;
	logic ready;
	rsp_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== sv/pldm_ram.sv =====
// Generic single-port RAM with registered read.
module pldm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule

// ===== sv/packet_loss_delay_monitor.sv =====
// Packet loss and one-way delay monitor: a packet request, clear or bin read takes one
// request in and gives one result out. After reset a clearing pass zeroes both
// histograms, during which no request is taken. With histograms enabled a packet goes
// from its acceptance through the update state, a bit-serial divider that finds both
// bins, the read states ST_RDREQ and ST_RDWAIT, the write-back state ST_WRITE and the
// result state ST_OUT. Other requests, and packets with histograms disabled, go from
// the update state straight to the result; an in-range bin read first waits for the
// RAM read. A result is held until it is taken, and no new request is taken before.
// The saturating 64-bit sums are each added in the update state.
module packet_loss_delay_monitor
	import pldm_pkg::*;
#(
	parameter int NUM_BINS = NUM_BINS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	pldm_req_if.sink    req,
	pldm_rsp_if.source  rsp
);
	`include "packet_loss_delay_monitor_macros.svh"

	localparam int AW = $clog2(NUM_BINS);
	localparam logic [AW-1:0] LAST_BIN = AW'(NUM_BINS - 1);

	typedef enum logic [3:0] {
		ST_CLEAR, ST_IDLE, ST_UPDATE, ST_DIV, ST_RDREQ, ST_RDWAIT, ST_WRITE, ST_BINRD,
		ST_BINWAIT, ST_OUT
	} state_t;

	state_t      state_q;
	req_t        req_q;
	logic [31:0] watched_q, dbw_q, vbw_q;
	logic        hen_q;
	logic [31:0] pkt_q, lost_q, exp_q, flow_q, last_d_q, prior_q, last_v_q, min_q;
	logic [63:0] bytes_q, dsum_q, vsum_q;
	logic        exp_valid_q, loss_q;
	logic [31:0] dcnt_q, vcnt_q;
	logic [AW-1:0] clr_q;
	logic [5:0]  bit_q;
	logic [31:0] dn_q, dr_q, vn_q, vr_q, dqt_q, vqt_q;
	logic [AW-1:0] dbin_q, vbin_q;
	logic        ram_we;
	logic [AW-1:0] daddr, vaddr;
	logic [31:0] dwdata, vwdata, drdata, vrdata;

	logic        wr;
	logic [31:0] d_new, var_new, gap;
	logic [32:0] dr_sh, vr_sh, dr_sub, vr_sub;
	logic [31:0] dw, vw;
	logic [64:0] bsum, dsum, vsum;

	assign pready = 1'b1;
	assign wr = psel && penable && pwrite;
	always_comb begin
		case (paddr[3:2])
			REG_FLOW: prdata = watched_q;
			REG_HEN:  prdata = {31'd0, hen_q};
			REG_DBW:  prdata = dbw_q;
			REG_VBW:  prdata = vbw_q;
			default:  prdata = '0;
		endcase
	end

	assign req.ready = (state_q == ST_IDLE);
	assign rsp.valid = (state_q == ST_OUT);
	assign rsp.data = '{pkt_q, bytes_q, lost_q, loss_q, flow_q, last_d_q, last_v_q, min_q,
		dsum_q, vsum_q, dcnt_q, vcnt_q};

	assign d_new = (req_q.arrival_time >= req_q.send_time) ?
		req_q.arrival_time - req_q.send_time : 32'd0;
	assign var_new = (prior_q < d_new) ? d_new - prior_q : prior_q - d_new;
	assign gap = req_q.seq_number - exp_q;
	assign bsum = {1'b0, bytes_q} + 65'(req_q.packet_bytes);
	assign dsum = {1'b0, dsum_q} + 65'(d_new);
	assign vsum = {1'b0, vsum_q} + 65'(var_new);
	assign dw = (dbw_q == 32'd0) ? 32'd1 : dbw_q;
	assign vw = (vbw_q == 32'd0) ? 32'd1 : vbw_q;
	assign dr_sh = {dr_q, dn_q[31]};
	assign vr_sh = {vr_q, vn_q[31]};
	assign dr_sub = dr_sh - {1'b0, dw};
	assign vr_sub = vr_sh - {1'b0, vw};

	assign ram_we = (state_q == ST_CLEAR) || (state_q == ST_WRITE);
	assign daddr = (state_q == ST_CLEAR) ? clr_q :
		(state_q == ST_BINRD) ? AW'(req_q.bin_index) : dbin_q;
	assign vaddr = (state_q == ST_CLEAR) ? clr_q :
		(state_q == ST_BINRD) ? AW'(req_q.bin_index) : vbin_q;
	assign dwdata = (state_q == ST_CLEAR) ? 32'd0 :
		((drdata == '1) ? drdata : drdata + 32'd1);
	assign vwdata = (state_q == ST_CLEAR) ? 32'd0 :
		((vrdata == '1) ? vrdata : vrdata + 32'd1);

	pldm_ram #(.WIDTH(32), .DEPTH(NUM_BINS)) u_dram (
		.clk(clk), .we(ram_we), .addr(daddr), .wdata(dwdata), .rdata(drdata));
	pldm_ram #(.WIDTH(32), .DEPTH(NUM_BINS)) u_vram (
		.clk(clk), .we(ram_we), .addr(vaddr), .wdata(vwdata), .rdata(vrdata));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			watched_q <= '0; hen_q <= 1'b0; dbw_q <= 32'd1; vbw_q <= 32'd1;
			pkt_q <= '0; bytes_q <= '0; lost_q <= '0; exp_q <= '0; exp_valid_q <= 1'b0;
			flow_q <= '0; last_d_q <= '0; prior_q <= '0; last_v_q <= '0; min_q <= '1;
			dsum_q <= '0; vsum_q <= '0; loss_q <= 1'b0; dcnt_q <= '0; vcnt_q <= '0;
			clr_q <= '0; bit_q <= '0;
			req_q <= '0; dn_q <= '0; vn_q <= '0; dr_q <= '0; vr_q <= '0;
			dqt_q <= '0; vqt_q <= '0; dbin_q <= '0; vbin_q <= '0;
		end else begin
			if (wr) begin
				case (paddr[3:2])
					REG_FLOW: watched_q <= pwdata;
					REG_HEN:  hen_q <= pwdata[0];
					REG_DBW:  dbw_q <= pwdata;
					REG_VBW:  vbw_q <= pwdata;
					default:  ;
				endcase
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == LAST_BIN) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (req.valid) begin
						req_q <= req.data;
						loss_q <= 1'b0; dcnt_q <= '0; vcnt_q <= '0;
						state_q <= ST_UPDATE;
					end
				end
				ST_UPDATE: begin
					state_q <= ST_OUT;
					case (req_q.command)
						CMD_PACKET: begin
							if (pkt_q != '1) pkt_q <= pkt_q + 32'd1;
							bytes_q <= bsum[64] ? '1 : bsum[63:0];
							if (req_q.flow_id == watched_q) begin
								if (flow_q != '1) flow_q <= flow_q + 32'd1;
								last_d_q <= d_new;
								if (d_new < min_q) min_q <= d_new;
								dsum_q <= dsum[64] ? '1 : dsum[63:0];
								if (prior_q != '0) begin
									last_v_q <= var_new;
									vsum_q <= vsum[64] ? '1 : vsum[63:0];
								end
								prior_q <= d_new;
							end
							if (exp_valid_q && gap != '0 && !gap[31]) begin
								lost_q <= ({1'b0, lost_q} + {1'b0, gap} > 33'hFFFFFFFF) ?
									'1 : lost_q + gap;
								loss_q <= 1'b1;
							end
							exp_q <= req_q.seq_number + 32'd1;
							exp_valid_q <= 1'b1;
							if (hen_q) begin
								state_q <= ST_DIV;
								bit_q <= '0;
								dr_q <= '0; vr_q <= '0; dqt_q <= '0; vqt_q <= '0;
								dn_q <= (req_q.flow_id == watched_q) ? d_new : last_d_q;
								vn_q <= (req_q.flow_id == watched_q && prior_q != '0) ?
									var_new : last_v_q;
							end
						end
						CMD_CLEAR: exp_valid_q <= 1'b0;
						CMD_READ: begin
							if (32'(req_q.bin_index) < 32'(NUM_BINS)) state_q <= ST_BINRD;
						end
						default: ;
					endcase
				end
				ST_DIV: begin
					bit_q <= bit_q + 6'd1;
					if (bit_q == 6'd32) begin
						dbin_q <= ((dqt_q + {31'd0, dr_q != '0}) >= 32'(NUM_BINS - 1) ||
							(dr_q != '0 && dqt_q == '1)) ? LAST_BIN :
							AW'(dqt_q + {31'd0, dr_q != '0});
						vbin_q <= ((vqt_q + {31'd0, vr_q != '0}) >= 32'(NUM_BINS - 1) ||
							(vr_q != '0 && vqt_q == '1)) ? LAST_BIN :
							AW'(vqt_q + {31'd0, vr_q != '0});
						state_q <= ST_RDREQ;
					end else begin
						dn_q <= {dn_q[30:0], 1'b0};
						vn_q <= {vn_q[30:0], 1'b0};
						dr_q <= dr_sub[32] ? dr_sh[31:0] : dr_sub[31:0];
						vr_q <= vr_sub[32] ? vr_sh[31:0] : vr_sub[31:0];
						dqt_q <= {dqt_q[30:0], !dr_sub[32]};
						vqt_q <= {vqt_q[30:0], !vr_sub[32]};
					end
				end
				ST_RDREQ:  state_q <= ST_RDWAIT;
				ST_RDWAIT: state_q <= ST_WRITE;
				ST_WRITE:  state_q <= ST_OUT;
				ST_BINRD:  state_q <= ST_BINWAIT;
				ST_BINWAIT: begin
					dcnt_q <= drdata; vcnt_q <= vrdata;
					state_q <= ST_OUT;
				end
				ST_OUT: if (rsp.ready) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`PLDM_ASSERT_IMP(a_no_accept_busy, clk, arst_n, state_q != ST_IDLE, !req.ready, "request taken while busy")
	`PLDM_ASSERT_IMP(a_loss_packet, clk, arst_n, rsp.valid && rsp.data.loss_event, req_q.command == CMD_PACKET, "loss flagged without packet")
	`PLDM_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp.valid && !rsp.ready, rsp.valid, "result dropped")
endmodule
